/* sv/cau_pkg.sv */
package cau_pkg;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   // control that travels with each pipeline slot
   typedef struct packed {
      logic valid;
      logic dz;
   } ctl_type;

endpackage

/* sv/cau_front.sv */
module cau_front import cau_pkg::*; #(
   parameter int DW = 16,
   parameter int F  = 8,
   parameter int VW = 2 * DW + 1,
   parameter int QW = VW + F,
   parameter int DENW = 2 * DW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [1:0]             kind,
   input  logic signed [DW-1:0]   a_real,
   input  logic signed [DW-1:0]   a_imag,
   input  logic signed [DW-1:0]   b_real,
   input  logic signed [DW-1:0]   b_imag,
   output ctl_type                ctl,
   output logic                   neg_re,
   output logic                   neg_im,
   output logic [QW-1:0]          work_re,
   output logic [QW-1:0]          work_im,
   output logic [DENW-1:0]        den
);

   // stage A: products and plain sums
   logic                  a_v_ff;
   kind_type              a_kind_ff;
   logic signed [2*DW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   logic signed [DW:0]    s_re_ff, s_im_ff;
   logic signed [DW:0]    s_re_in, s_im_in;

   always_comb begin
      if (kind_type'(kind) == KIND_SUB) begin
         s_re_in = {a_real[DW-1], a_real} - {b_real[DW-1], b_real};
         s_im_in = {a_imag[DW-1], a_imag} - {b_imag[DW-1], b_imag};
      end else begin
         s_re_in = {a_real[DW-1], a_real} + {b_real[DW-1], b_real};
         s_im_in = {a_imag[DW-1], a_imag} + {b_imag[DW-1], b_imag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
      end
      if (en) begin
         a_kind_ff <= kind_type'(kind);
         p_rr_ff   <= a_real * b_real;
         p_ii_ff   <= a_imag * b_imag;
         p_ri_ff   <= a_real * b_imag;
         p_ir_ff   <= a_imag * b_real;
         sq_r_ff   <= b_real * b_real;
         sq_i_ff   <= b_imag * b_imag;
         s_re_ff   <= s_re_in;
         s_im_ff   <= s_im_in;
      end
   end

   // stage B: combine cross products (or take the sums) into one signed value per part
   logic                   b_v_ff, b_div_ff, b_dz_ff;
   logic signed [VW-1:0]   b_re_ff, b_im_ff;
   logic [DENW-1:0]        b_den_ff;
   logic signed [VW-1:0]   b_re_in, b_im_in;
   logic [DENW-1:0]        den_sum;
   logic signed [VW-1:0]   e_rr, e_ii, e_ri, e_ir;

   assign e_rr = VW'(p_rr_ff);
   assign e_ii = VW'(p_ii_ff);
   assign e_ri = VW'(p_ri_ff);
   assign e_ir = VW'(p_ir_ff);
   assign den_sum = DENW'($unsigned(sq_r_ff)) + DENW'($unsigned(sq_i_ff));

   always_comb begin
      case (a_kind_ff)
         KIND_MUL: begin
            b_re_in = (e_rr - e_ii) >>> F;
            b_im_in = (e_ri + e_ir) >>> F;
         end
         KIND_DIV: begin
            b_re_in = e_rr + e_ii;
            b_im_in = e_ir - e_ri;
         end
         default: begin
            b_re_in = VW'(s_re_ff);
            b_im_in = VW'(s_im_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
      if (en) begin
         b_re_ff  <= b_re_in;
         b_im_ff  <= b_im_in;
         b_den_ff <= den_sum;
         b_div_ff <= (a_kind_ff == KIND_DIV);
         b_dz_ff  <= (a_kind_ff == KIND_DIV) && (den_sum == '0);
      end
   end

   // stage C: sign and magnitude, divider operands
   logic                  c_v_ff, c_dz_ff, c_nre_ff, c_nim_ff;
   logic [QW-1:0]         c_wre_ff, c_wim_ff;
   logic [DENW-1:0]       c_den_ff;
   logic [VW-1:0]         m_re, m_im;

   assign m_re = b_re_ff[VW-1] ? VW'(-b_re_ff) : VW'(b_re_ff);
   assign m_im = b_im_ff[VW-1] ? VW'(-b_im_ff) : VW'(b_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
      if (en) begin
         c_dz_ff  <= b_dz_ff;
         c_nre_ff <= b_re_ff[VW-1];
         c_nim_ff <= b_im_ff[VW-1];
         if (b_dz_ff) begin
            c_wre_ff <= '0;
            c_wim_ff <= '0;
            c_den_ff <= DENW'(1);
         end else if (b_div_ff) begin
            c_wre_ff <= QW'(m_re) << F;
            c_wim_ff <= QW'(m_im) << F;
            c_den_ff <= b_den_ff;
         end else begin
            // divide by one to pass the value through unchanged
            c_wre_ff <= QW'(m_re);
            c_wim_ff <= QW'(m_im);
            c_den_ff <= DENW'(1);
         end
      end
   end

   assign ctl       = '{valid: c_v_ff, dz: c_dz_ff};
   assign neg_re    = c_nre_ff;
   assign neg_im    = c_nim_ff;
   assign work_re   = c_wre_ff;
   assign work_im   = c_wim_ff;
   assign den       = c_den_ff;

endmodule

/* sv/cau_div_stage.sv */
module cau_div_stage import cau_pkg::*; #(
   parameter int QW = 41,
   parameter int DENW = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ctl_type           ctl_i,
   input  logic              neg_re_i,
   input  logic              neg_im_i,
   input  logic [QW-1:0]     work_re_i,
   input  logic [QW-1:0]     work_im_i,
   input  logic [DENW-1:0]   rem_re_i,
   input  logic [DENW-1:0]   rem_im_i,
   input  logic [DENW-1:0]   den_i,
   output ctl_type           ctl_o,
   output logic              neg_re_o,
   output logic              neg_im_o,
   output logic [QW-1:0]     work_re_o,
   output logic [QW-1:0]     work_im_o,
   output logic [DENW-1:0]   rem_re_o,
   output logic [DENW-1:0]   rem_im_o,
   output logic [DENW-1:0]   den_o
);

   // one restoring step per part: shift in the next dividend bit, subtract if it fits
   logic [DENW:0]   t_re, t_im;
   logic            ge_re, ge_im;
   ctl_type         ctl_ff;
   logic            nre_ff, nim_ff;
   logic [QW-1:0]   wre_ff, wim_ff;
   logic [DENW-1:0] rre_ff, rim_ff, den_ff;

   assign t_re  = {rem_re_i, work_re_i[QW-1]};
   assign t_im  = {rem_im_i, work_im_i[QW-1]};
   assign ge_re = t_re >= {1'b0, den_i};
   assign ge_im = t_im >= {1'b0, den_i};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
      if (en) begin
         nre_ff <= neg_re_i;
         nim_ff <= neg_im_i;
         wre_ff <= {work_re_i[QW-2:0], ge_re};
         wim_ff <= {work_im_i[QW-2:0], ge_im};
         rre_ff <= ge_re ? DENW'(t_re - {1'b0, den_i}) : t_re[DENW-1:0];
         rim_ff <= ge_im ? DENW'(t_im - {1'b0, den_i}) : t_im[DENW-1:0];
         den_ff <= den_i;
      end
   end

   assign ctl_o     = ctl_ff;
   assign neg_re_o  = nre_ff;
   assign neg_im_o  = nim_ff;
   assign work_re_o = wre_ff;
   assign work_im_o = wim_ff;
   assign rem_re_o  = rre_ff;
   assign rem_im_o  = rim_ff;
   assign den_o     = den_ff;

endmodule

/* sv/cau_sat.sv */
module cau_sat import cau_pkg::*; #(
   parameter int DW = 16,
   parameter int QW = 41
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ctl_type           ctl_i,
   input  logic              neg_re_i,
   input  logic              neg_im_i,
   input  logic [QW-1:0]     q_re_i,
   input  logic [QW-1:0]     q_im_i,
   output logic              valid_o,
   output logic [DW-1:0]     res_real,
   output logic [DW-1:0]     res_imag,
   output logic              overflow,
   output logic              div_by_zero
);

   localparam logic [QW-1:0] HALF = QW'(1) << (DW - 1);

   logic            v_ff, ovf_ff, dz_ff;
   logic [DW-1:0]   re_ff, im_ff;
   logic [DW-1:0]   re_in, im_in;
   logic            o_re, o_im;

   // clamp a sign/magnitude value to the signed word range
   always_comb begin
      if (neg_re_i) begin
         o_re  = q_re_i > HALF;
         re_in = o_re ? DW'(HALF) : DW'(-q_re_i);
      end else begin
         o_re  = q_re_i > HALF - QW'(1);
         re_in = o_re ? DW'(HALF - QW'(1)) : DW'(q_re_i);
      end
      if (neg_im_i) begin
         o_im  = q_im_i > HALF;
         im_in = o_im ? DW'(HALF) : DW'(-q_im_i);
      end else begin
         o_im  = q_im_i > HALF - QW'(1);
         im_in = o_im ? DW'(HALF - QW'(1)) : DW'(q_im_i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= ctl_i.valid;
      end
      if (en) begin
         re_ff  <= re_in;
         im_ff  <= im_in;
         ovf_ff <= o_re | o_im;
         dz_ff  <= ctl_i.dz;
      end
   end

   assign valid_o     = v_ff;
   assign res_real    = re_ff;
   assign res_imag    = im_ff;
   assign overflow    = ovf_ff;
   assign div_by_zero = dz_ff;

endmodule

/* sv/complex_arithmetic_unit_top.sv */
// Complex arithmetic unit: adds, subtracts, multiplies or divides two signed fixed-point
// complex operands (Q8.8 by default) and returns a saturated complex result with overflow
// and divide-by-zero flags. One transfer is accepted every cycle while the result side takes
// results. Every kind passes through the bit-per-stage restoring divider (non-divide
// items divide by one). The whole pipeline advances together, so a stall on
// rsp_tready holds every stage and req_tready falls with it. A zero divisor gives zero parts
// and div_by_zero.
module complex_arithmetic_unit_top import cau_pkg::*; #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_real, a_imag, b_real, b_imag from the lowest bit up, zero padded to bytes
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // res_real, res_imag from the lowest bit up, zero padded to bytes
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // overflow, div_by_zero from the lowest bit up
   output logic [1:0] rsp_tuser
);

   localparam int DW   = DATA_WIDTH;
   localparam int VW   = 2 * DW + 1;
   localparam int QW   = VW + FRAC_BITS;
   localparam int DENW = 2 * DW;
   localparam int OTW  = ((2*DATA_WIDTH+7)/8)*8;

   logic en;
   logic [DW-1:0] res_real, res_imag;
   logic overflow, div_by_zero;

   // advance everything unless a finished result is waiting
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   ctl_type         ctl_s   [QW+1];
   logic            nre_s   [QW+1];
   logic            nim_s   [QW+1];
   logic [QW-1:0]   wre_s   [QW+1];
   logic [QW-1:0]   wim_s   [QW+1];
   logic [DENW-1:0] rre_s   [QW+1];
   logic [DENW-1:0] rim_s   [QW+1];
   logic [DENW-1:0] den_s   [QW+1];

   cau_front #(.DW(DW), .F(FRAC_BITS), .VW(VW), .QW(QW), .DENW(DENW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .kind     (req_tuser),
      .a_real   (req_tdata[DW-1:0]),
      .a_imag   (req_tdata[2*DW-1:DW]),
      .b_real   (req_tdata[3*DW-1:2*DW]),
      .b_imag   (req_tdata[4*DW-1:3*DW]),
      .ctl      (ctl_s[0]),
      .neg_re   (nre_s[0]),
      .neg_im   (nim_s[0]),
      .work_re  (wre_s[0]),
      .work_im  (wim_s[0]),
      .den      (den_s[0])
   );

   assign rre_s[0] = '0;
   assign rim_s[0] = '0;

   // one quotient bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_div
      cau_div_stage #(.QW(QW), .DENW(DENW)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .ctl_i     (ctl_s[i]),
         .neg_re_i  (nre_s[i]),
         .neg_im_i  (nim_s[i]),
         .work_re_i (wre_s[i]),
         .work_im_i (wim_s[i]),
         .rem_re_i  (rre_s[i]),
         .rem_im_i  (rim_s[i]),
         .den_i     (den_s[i]),
         .ctl_o     (ctl_s[i+1]),
         .neg_re_o  (nre_s[i+1]),
         .neg_im_o  (nim_s[i+1]),
         .work_re_o (wre_s[i+1]),
         .work_im_o (wim_s[i+1]),
         .rem_re_o  (rre_s[i+1]),
         .rem_im_o  (rim_s[i+1]),
         .den_o     (den_s[i+1])
      );
   end

   cau_sat #(.DW(DW), .QW(QW)) u_sat (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .ctl_i       (ctl_s[QW]),
      .neg_re_i    (nre_s[QW]),
      .neg_im_i    (nim_s[QW]),
      .q_re_i      (wre_s[QW]),
      .q_im_i      (wim_s[QW]),
      .valid_o     (rsp_tvalid),
      .res_real    (res_real),
      .res_imag    (res_imag),
      .overflow    (overflow),
      .div_by_zero (div_by_zero)
   );

   assign rsp_tdata = OTW'({res_imag, res_real});
   assign rsp_tuser = {div_by_zero, overflow};

   // a zero divisor never saturates and always yields zero parts
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && div_by_zero |-> !overflow && res_real == '0 && res_imag == '0)
      else $error("divide by zero result not clean");

   // a saturated result holds an extreme code in at least one part
   a_ovf_extreme : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && overflow |->
         res_real == {1'b1, {(DW-1){1'b0}}} || res_real == {1'b0, {(DW-1){1'b1}}} ||
         res_imag == {1'b1, {(DW-1){1'b0}}} || res_imag == {1'b0, {(DW-1){1'b1}}})
      else $error("overflow without a saturated part");

   // a stalled result stays put
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

/* tb/tb_complex_arithmetic_unit_top.sv */
module tb_complex_arithmetic_unit_top import cau_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW        = 16;
   localparam int FB        = 8;
   localparam int LATENCY   = 4 + 2*DW + 1 + FB;
   localparam int N_RANDOM  = 1430;

   typedef struct packed {
      logic [DW-1:0] re;
      logic [DW-1:0] im;
      logic          ovf;
      logic          dz;
   } cplx_result_type;

   // Expected results, oldest first; also counts failures
   class cplx_scoreboard;
      cplx_result_type pending[$];
      int unsigned  errors;
      int unsigned  checked;
      int unsigned  n_ovf;
      int unsigned  n_dz;

      // saturate a wide signed value to DW bits
      function automatic logic [DW-1:0] clamp(longint v, inout logic ovf);
         longint hi, lo;
         hi = (longint'(1) <<< (DW-1)) - 1;
         lo = -(longint'(1) <<< (DW-1));
         if (v > hi) begin
            ovf = 1'b1;
            return hi[DW-1:0];
         end
         if (v < lo) begin
            ovf = 1'b1;
            return lo[DW-1:0];
         end
         return v[DW-1:0];
      endfunction

      // numerator * 2^FB / den, truncated toward zero
      function automatic longint quot(longint num, longint den);
         longint q;
         logic   neg;
         neg = num < 0;
         q   = ((neg ? -num : num) <<< FB) / den;
         return neg ? -q : q;
      endfunction

      function automatic cplx_result_type compute(kind_type k, logic signed [DW-1:0] ar,
                                                  logic signed [DW-1:0] ai,
                                                  logic signed [DW-1:0] br,
                                                  logic signed [DW-1:0] bi);
         cplx_result_type r;
         longint pr, pi, den;
         r = '0;
         case (k)
            KIND_ADD: begin
               pr = longint'(ar) + br;
               pi = longint'(ai) + bi;
            end
            KIND_SUB: begin
               pr = longint'(ar) - br;
               pi = longint'(ai) - bi;
            end
            KIND_MUL: begin
               pr = (longint'(ar) * br - longint'(ai) * bi) >>> FB;
               pi = (longint'(ar) * bi + longint'(ai) * br) >>> FB;
            end
            default: begin
               den = longint'(br) * br + longint'(bi) * bi;
               if (den == 0) begin
                  r.dz = 1'b1;
                  return r;
               end
               pr = quot(longint'(ar) * br + longint'(ai) * bi, den);
               pi = quot(longint'(ai) * br - longint'(ar) * bi, den);
            end
         endcase
         r.re = clamp(pr, r.ovf);
         r.im = clamp(pi, r.ovf);
         return r;
      endfunction

      function void note_request(kind_type k, logic [DW-1:0] ar, logic [DW-1:0] ai,
                                 logic [DW-1:0] br, logic [DW-1:0] bi);
         pending.push_back(compute(k, ar, ai, br, bi));
      endfunction

      function void check_response(logic [DW-1:0] re, logic [DW-1:0] im,
                                   logic ovf, logic dz);
         cplx_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result re=%h im=%h ovf=%b dz=%b",
                     $realtime, re, im, ovf, dz);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         n_ovf += ovf;
         n_dz  += dz;
         if (re !== e.re) begin
            $display("%0t: res_real expected %h actual %h", $realtime, e.re, re);
            errors++;
         end
         if (im !== e.im) begin
            $display("%0t: res_imag expected %h actual %h", $realtime, e.im, im);
            errors++;
         end
         if (ovf !== e.ovf) begin
            $display("%0t: overflow expected %b actual %b", $realtime, e.ovf, ovf);
            errors++;
         end
         if (dz !== e.dz) begin
            $display("%0t: div_by_zero expected %b actual %b", $realtime, e.dz, dz);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_tvalid;
   logic            req_tready;
   logic [4*DW-1:0] req_tdata;   // a_real, a_imag, b_real, b_imag from the lowest bit up
   logic [1:0]      req_tuser;   // kind
   logic            rsp_tvalid;
   logic            rsp_tready;
   logic [2*DW-1:0] rsp_tdata;   // res_real, res_imag from the lowest bit up
   logic [1:0]      rsp_tuser;   // overflow, div_by_zero from the lowest bit up

   cplx_scoreboard sb;
   bit             hold_off_rsp;   // request a long receiver stall
   bit             hold_off_done;
   bit             stim_done;

   complex_arithmetic_unit_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Random operand with a bias towards the corners of the range
   function automatic logic [DW-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 1024)) - 512);  // small magnitudes
         4: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one item and hold it until the transfer completes
   task automatic send_item(kind_type k, logic [DW-1:0] ar, logic [DW-1:0] ai,
                            logic [DW-1:0] br, logic [DW-1:0] bi);
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {bi, br, ai, ar};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(k, ar, ai, br, bi);
   endtask

   task automatic go_idle(int unsigned cycles);
      req_tvalid <= 1'b0;
      req_tdata  <= 64'($urandom) << 32 | 64'($urandom);  // junk while idle
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall pattern, with stretches of constant readiness and one long
   // hold-off on request
   initial begin
      int unsigned mode;
      int unsigned run;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off_rsp && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         run  = $urandom_range(1, 40);
         repeat (run) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Sample results as they stand at the accepting edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[DW-1:0], rsp_tdata[2*DW-1:DW], rsp_tuser[0], rsp_tuser[1]);
   end

   // Stimulus
   initial begin
      int unsigned sent;
      int unsigned burst;
      int unsigned k;
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_ADD;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: each kind, saturation both ways, zero divisor, rounding signs
      send_item(KIND_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
      send_item(KIND_ADD, 16'h0100, 16'hff00, 16'h0280, 16'h0040);
      send_item(KIND_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
      send_item(KIND_SUB, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(KIND_MUL, 16'h0100, 16'h0000, 16'h0123, 16'hfedc);
      send_item(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(KIND_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
      send_item(KIND_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
      send_item(KIND_MUL, 16'h0001, 16'h0001, 16'h0001, 16'hffff);
      send_item(KIND_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
      send_item(KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(KIND_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
      send_item(KIND_DIV, 16'hff00, 16'h0100, 16'h0300, 16'hfd00);
      send_item(KIND_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
      send_item(KIND_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001);
      send_item(KIND_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h8000);
      send_item(KIND_DIV, 16'hffff, 16'h0001, 16'h0003, 16'h0000);
      send_item(KIND_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
      send_item(KIND_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_item(KIND_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);

      // pause until every result is back
      wait_drained();

      // random part in bursts; the long receiver hold-off falls near the start
      sent = 0;
      while (sent < N_RANDOM) begin
         if (sent > 100 && !hold_off_rsp) hold_off_rsp = 1'b1;
         if (sent > 700 && sent < 720) wait_drained();
         burst = $urandom_range(1, 60);
         repeat (burst) begin
            k = $urandom_range(0, 3);
            if (k == KIND_DIV && $urandom_range(0, 15) == 0)
               send_item(KIND_DIV, pick_operand(), pick_operand(), 16'h0000, 16'h0000);
            else
               send_item(kind_type'(k), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
      end

      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      stim_done = 1'b1;
   end

   // Report once the stimulus side is finished
   initial begin
      wait (stim_done);
      $display("Checked %0d results over all four kinds (%0d saturated, %0d zero divisors)",
               sb.checked, sb.n_ovf, sb.n_dz);
      $display("Bursty input, random result stalls and one long hold-off exercised");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
